/* rtl/wtsc_pkg.sv */
// Package for the watch time-setting control block: button codes, field codes,
// wrap limits and the calendar helpers for the day-of-month wrap.
// Depends on nothing; used by rtl/watch_time_setting_control.sv.
package wtsc_pkg;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_A    = 2'd1,
		CMD_B    = 2'd2,
		CMD_C    = 2'd3
	} cmd_t;

	// Field selector codes. Codes six and seven are never reached in normal use.
	localparam logic [2:0] FLD_SEC   = 3'd0;
	localparam logic [2:0] FLD_HOUR  = 3'd1;
	localparam logic [2:0] FLD_MIN   = 3'd2;
	localparam logic [2:0] FLD_YEAR  = 3'd3;
	localparam logic [2:0] FLD_MONTH = 3'd4;
	localparam logic [2:0] FLD_DAY   = 3'd5;
	localparam logic [3:0] NUM_FIELDS = 4'd6;

	localparam logic [6:0] SEC_LIMIT   = 7'd60;
	localparam logic [6:0] MIN_LIMIT   = 7'd60;
	localparam logic [5:0] HOUR_LIMIT  = 6'd24;
	localparam logic [4:0] MONTH_LIMIT = 5'd12;
	localparam logic [8:0] YEAR_LAST   = 9'd199;
	localparam logic [7:0] YEAR_FIRST  = 8'd119;

	// Reset values of the edit copy.
	localparam logic [4:0] MDAY_RESET = 5'd1;
	localparam logic [7:0] YEAR_RESET = 8'd119;

	// Leap test on 1900 + year for year in 0..255. The full year is a multiple
	// of four exactly when the offset is; 1900 and 2100 are century years that
	// are not leap years, whereas 2000 is.
	function automatic logic is_leap(input logic [7:0] year);
		logic leap;
		leap = (year[1:0] == 2'b00) && (year != 8'd0) && (year != 8'd200);
		return leap;
	endfunction

	// Days in a month; month codes twelve to fifteen count as thirty days.
	function automatic logic [5:0] month_days(input logic [3:0] month,
	                                          input logic [7:0] year);
		logic [5:0] days;
		case (month)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 6'd31;
			4'd1: days = is_leap(year) ? 6'd29 : 6'd28;
			default: days = 6'd30;
		endcase
		return days;
	endfunction

endpackage

/* rtl/watch_time_setting_control.sv */
// Top level of the watch time-setting control: button decoding, the edit copy
// of the clock and the registered result stage.
// Depends on rtl/wtsc_pkg.sv.

// Usage
// The block handles the buttons of a watch in its timekeeping mode. Each input
// transaction carries a button code, an active flag and a snapshot of the
// running clock; each one produces exactly one result transaction giving the
// setting flag, the selected field, a leave-mode request, a write-back strobe
// and the edit copy of the time.
// Both channels use valid and stall: a transaction moves on a rising edge at
// which valid is high and stall is low.
// A transaction's result is loaded into the result register at the edge that
// accepts it and presented from then on. Throughput is one transaction per
// cycle unless the receiver stalls, set by the single result register;
// a button's state update is one short increment-and-wrap step, finished in
// the cycle of acceptance, so the next transaction sees it at once.
// When the receiver stalls, the result register holds its contents and input
// stall rises only while that register is full and stalled; as soon as the
// result is taken, a new transaction is accepted in the same cycle.
// Reset clears the setting submode, selects seconds and sets the edit copy to
// midnight on the first of January 2019; no result is pending after reset.
module watch_time_setting_control (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic       active,
	input  logic [5:0] cur_sec,
	input  logic [5:0] cur_min,
	input  logic [4:0] cur_hour,
	input  logic [4:0] cur_mday,
	input  logic [3:0] cur_month,
	input  logic [7:0] cur_year,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       setting_on,
	output logic [2:0] field_sel,
	output logic       leave_mode,
	output logic       write_clock,
	output logic [5:0] out_sec,
	output logic [5:0] out_min,
	output logic [4:0] out_hour,
	output logic [4:0] out_mday,
	output logic [3:0] out_month,
	output logic [7:0] out_year
);

	wtsc_pkg::cmd_t cmd_code;
	logic           accept;

	// Architectural state: submode flag, selector and edit copy.
	logic       in_setting_q;
	logic [2:0] sel_q;
	logic [5:0] edit_sec_q;
	logic [5:0] edit_min_q;
	logic [4:0] edit_hour_q;
	logic [4:0] edit_mday_q;
	logic [3:0] edit_month_q;
	logic [7:0] edit_year_q;

	logic       in_setting_nxt;
	logic [2:0] sel_nxt;
	logic [5:0] edit_sec_nxt;
	logic [5:0] edit_min_nxt;
	logic [4:0] edit_hour_nxt;
	logic [4:0] edit_mday_nxt;
	logic [3:0] edit_month_nxt;
	logic [7:0] edit_year_nxt;
	logic       leave_nxt;
	logic       write_nxt;

	// Incremented and wrapped value of each field.
	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [4:0] month_inc;
	logic [8:0] year_inc;
	logic [5:0] mday_inc;
	logic [3:0] sel_inc;
	logic [5:0] sec_wrap;
	logic [5:0] min_wrap;
	logic [4:0] hour_wrap;
	logic [3:0] month_wrap;
	logic [7:0] year_wrap;
	logic [4:0] mday_wrap;
	logic [2:0] sel_wrap;

	// The result register is the only buffer, so the input waits only while a
	// result is held there and the receiver is stalling.
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;
	assign cmd_code = wtsc_pkg::cmd_t'(cmd);

	// Seconds, minutes, hours, month and selector wrap by a compare and subtract,
	// as each incremented value stays below twice its modulus, even out of range.
	always_comb begin
		sec_inc   = {1'b0, edit_sec_q} + 7'd1;
		min_inc   = {1'b0, edit_min_q} + 7'd1;
		hour_inc  = {1'b0, edit_hour_q} + 6'd1;
		month_inc = {1'b0, edit_month_q} + 5'd1;
		year_inc  = {1'b0, edit_year_q} + 9'd1;
		mday_inc  = {1'b0, edit_mday_q} + 6'd1;
		sel_inc   = {1'b0, sel_q} + 4'd1;

		sec_wrap   = (sec_inc >= wtsc_pkg::SEC_LIMIT) ?
		             6'(sec_inc - wtsc_pkg::SEC_LIMIT) : sec_inc[5:0];
		min_wrap   = (min_inc >= wtsc_pkg::MIN_LIMIT) ?
		             6'(min_inc - wtsc_pkg::MIN_LIMIT) : min_inc[5:0];
		hour_wrap  = (hour_inc >= wtsc_pkg::HOUR_LIMIT) ?
		             5'(hour_inc - wtsc_pkg::HOUR_LIMIT) : hour_inc[4:0];
		month_wrap = (month_inc >= wtsc_pkg::MONTH_LIMIT) ?
		             4'(month_inc - wtsc_pkg::MONTH_LIMIT) : month_inc[3:0];
		year_wrap  = (year_inc > wtsc_pkg::YEAR_LAST) ?
		             wtsc_pkg::YEAR_FIRST : year_inc[7:0];
		// A day beyond the month length, including one copied in out of range,
		// falls back to the first.
		mday_wrap  = (mday_inc > wtsc_pkg::month_days(edit_month_q, edit_year_q)) ?
		             5'd1 : mday_inc[4:0];
		sel_wrap   = (sel_inc >= wtsc_pkg::NUM_FIELDS) ?
		             3'(sel_inc - wtsc_pkg::NUM_FIELDS) : sel_inc[2:0];
	end

	// Button decoding. An inactive transaction changes nothing and reports the
	// present state with both strobes low.
	always_comb begin
		in_setting_nxt = in_setting_q;
		sel_nxt        = sel_q;
		edit_sec_nxt   = edit_sec_q;
		edit_min_nxt   = edit_min_q;
		edit_hour_nxt  = edit_hour_q;
		edit_mday_nxt  = edit_mday_q;
		edit_month_nxt = edit_month_q;
		edit_year_nxt  = edit_year_q;
		leave_nxt      = 1'b0;
		write_nxt      = 1'b0;
		if (active) begin
			if (!in_setting_q) begin
				case (cmd_code)
					wtsc_pkg::CMD_C: begin
						leave_nxt = 1'b1;
					end
					wtsc_pkg::CMD_A: begin
						edit_sec_nxt   = cur_sec;
						edit_min_nxt   = cur_min;
						edit_hour_nxt  = cur_hour;
						edit_mday_nxt  = cur_mday;
						edit_month_nxt = cur_month;
						edit_year_nxt  = cur_year;
						in_setting_nxt = 1'b1;
						sel_nxt        = wtsc_pkg::FLD_SEC;
					end
					default: begin
					end
				endcase
			end else begin
				case (cmd_code)
					wtsc_pkg::CMD_C: begin
						sel_nxt = sel_wrap;
					end
					wtsc_pkg::CMD_B: begin
						// An unreachable selector changes no field but still writes back.
						write_nxt = 1'b1;
						case (sel_q)
							wtsc_pkg::FLD_SEC:   edit_sec_nxt   = sec_wrap;
							wtsc_pkg::FLD_HOUR:  edit_hour_nxt  = hour_wrap;
							wtsc_pkg::FLD_MIN:   edit_min_nxt   = min_wrap;
							wtsc_pkg::FLD_YEAR:  edit_year_nxt  = year_wrap;
							wtsc_pkg::FLD_MONTH: edit_month_nxt = month_wrap;
							wtsc_pkg::FLD_DAY:   edit_mday_nxt  = mday_wrap;
							default: begin
							end
						endcase
					end
					wtsc_pkg::CMD_A: begin
						write_nxt      = 1'b1;
						in_setting_nxt = 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_setting_q <= 1'b0;
			sel_q        <= wtsc_pkg::FLD_SEC;
			edit_sec_q   <= 6'd0;
			edit_min_q   <= 6'd0;
			edit_hour_q  <= 5'd0;
			edit_mday_q  <= wtsc_pkg::MDAY_RESET;
			edit_month_q <= 4'd0;
			edit_year_q  <= wtsc_pkg::YEAR_RESET;
		end else if (accept) begin
			in_setting_q <= in_setting_nxt;
			sel_q        <= sel_nxt;
			edit_sec_q   <= edit_sec_nxt;
			edit_min_q   <= edit_min_nxt;
			edit_hour_q  <= edit_hour_nxt;
			edit_mday_q  <= edit_mday_nxt;
			edit_month_q <= edit_month_nxt;
			edit_year_q  <= edit_year_nxt;
		end
	end

	// Result register: the valid flag is control state and is reset; the
	// payload is loaded only on acceptance and otherwise holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			setting_on  <= in_setting_nxt;
			field_sel   <= sel_nxt;
			leave_mode  <= leave_nxt;
			write_clock <= write_nxt;
			out_sec     <= edit_sec_nxt;
			out_min     <= edit_min_nxt;
			out_hour    <= edit_hour_nxt;
			out_mday    <= edit_mday_nxt;
			out_month   <= edit_month_nxt;
			out_year    <= edit_year_nxt;
		end
	end

endmodule

/* test/watch_time_setting_control_test.sv */
// Self-checking testbench for watch_time_setting_control: button transactions in,
// edit-copy results out, checked against a behavioural model of the button handler.
// Depends on rtl/wtsc_pkg.sv and rtl/watch_time_setting_control.sv.
module watch_time_setting_control_test;
	timeunit 1ns;
	timeprecision 1ps;

	// One snapshot of the clock, used for the running clock and the edit copy alike.
	typedef struct {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] mday;
		logic [3:0] month;
		logic [7:0] year;
	} clock_time_t;

	// A button transaction together with the idling that surrounds it: the cycles
	// the sender waits before offering it, the cycles the receiver stalls once its
	// result has been taken, and whether the sender first waits for every result.
	typedef struct {
		wtsc_pkg::cmd_t cmd;
		logic           active;
		clock_time_t    snap;
		int             tx_gap;
		int             rx_gap;
		bit             drain;
	} button_press_t;

	typedef struct {
		logic        setting;
		logic [2:0]  field;
		logic        leave;
		logic        write;
		clock_time_t edit;
		int          rx_gap;
	} watch_update_t;

	// Every input is given a known value from time zero.
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] cmd = 2'd0;
	logic       active = 1'b0;
	logic [5:0] cur_sec = 6'd0;
	logic [5:0] cur_min = 6'd0;
	logic [4:0] cur_hour = 5'd0;
	logic [4:0] cur_mday = 5'd1;
	logic [3:0] cur_month = 4'd0;
	logic [7:0] cur_year = 8'd119;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       setting_on;
	logic [2:0] field_sel;
	logic       leave_mode;
	logic       write_clock;
	logic [5:0] out_sec;
	logic [5:0] out_min;
	logic [4:0] out_hour;
	logic [4:0] out_mday;
	logic [3:0] out_month;
	logic [7:0] out_year;

	watch_time_setting_control dut (.*);

	// Button transactions waiting to be offered, and the results still owed by the block.
	button_press_t press_q[$];
	watch_update_t update_q[$];

	// The model's own copy of the block's state, starting from the reset values.
	logic        watch_setting = 1'b0;
	logic [2:0]  watch_field = wtsc_pkg::FLD_SEC;
	clock_time_t watch_edit = '{6'd0, 6'd0, 5'd0, wtsc_pkg::MDAY_RESET, 4'd0,
		wtsc_pkg::YEAR_RESET};

	// Bookkeeping for the generator, the driver and the monitor.
	int  n_queued = 0;
	int  n_active = 0;
	bit  plan_setting = 1'b0;
	int  n_accepted = 0;
	int  n_in_stalls = 0;
	int  n_checked = 0;
	int  n_errors = 0;
	int  n_writes = 0;
	int  n_leaves = 0;
	bit  have_press = 1'b0;
	int  tx_wait = 0;
	int  rx_wait = 0;
	logic rx_block = 1'b0;
	button_press_t cur_press;

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Behavioural model of the button handler
	// ------------------------------------------------------------------

	// Gregorian leap test on the full year, that is 1900 plus the stored offset.
	function automatic bit leap_year(logic [7:0] year);
		int full;
		full = 1900 + int'(year);
		return ((full % 4 == 0) && (full % 100 != 0)) || (full % 400 == 0);
	endfunction

	// Month codes above eleven cannot name a real month; they count as thirty days.
	function automatic int days_in_month(logic [3:0] month, logic [7:0] year);
		case (month)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: return 31;
			4'd1: return leap_year(year) ? 29 : 28;
			default: return 30;
		endcase
	endfunction

	// Applies one accepted button transaction to the model state and returns the
	// result the block should give for it. Inactive transactions change nothing.
	function automatic watch_update_t apply_press(button_press_t p);
		watch_update_t u;
		int bumped;
		u.leave = 1'b0;
		u.write = 1'b0;
		if (p.active) begin
			if (!watch_setting) begin
				// Outside setting only A and C matter; B is ignored.
				if (p.cmd == wtsc_pkg::CMD_C) begin
					u.leave = 1'b1;
				end else if (p.cmd == wtsc_pkg::CMD_A) begin
					watch_edit = p.snap;
					watch_setting = 1'b1;
					watch_field = wtsc_pkg::FLD_SEC;
				end
			end else begin
				case (p.cmd)
					wtsc_pkg::CMD_C: begin
						watch_field = 3'((int'(watch_field) + 1) %
							int'(wtsc_pkg::NUM_FIELDS));
					end
					wtsc_pkg::CMD_B: begin
						// Every B press writes back, even when the selector names no field.
						u.write = 1'b1;
						case (watch_field)
							wtsc_pkg::FLD_SEC: begin
								watch_edit.sec = 6'((int'(watch_edit.sec) + 1) %
									int'(wtsc_pkg::SEC_LIMIT));
							end
							wtsc_pkg::FLD_MIN: begin
								watch_edit.min = 6'((int'(watch_edit.min) + 1) %
									int'(wtsc_pkg::MIN_LIMIT));
							end
							wtsc_pkg::FLD_HOUR: begin
								watch_edit.hour = 5'((int'(watch_edit.hour) + 1) %
									int'(wtsc_pkg::HOUR_LIMIT));
							end
							wtsc_pkg::FLD_MONTH: begin
								watch_edit.month = 4'((int'(watch_edit.month) + 1) %
									int'(wtsc_pkg::MONTH_LIMIT));
							end
							wtsc_pkg::FLD_YEAR: begin
								// Beyond 2099 the year goes back to 2019.
								bumped = int'(watch_edit.year) + 1;
								watch_edit.year = (bumped > int'(wtsc_pkg::YEAR_LAST)) ?
									wtsc_pkg::YEAR_FIRST : 8'(bumped);
							end
							wtsc_pkg::FLD_DAY: begin
								// A day past the month's end, and a day of zero, both come
								// out as one.
								bumped = int'(watch_edit.mday) + 1;
								watch_edit.mday = (bumped > days_in_month(watch_edit.month,
									watch_edit.year)) ? 5'd1 : 5'(bumped);
							end
							default: ;
						endcase
					end
					wtsc_pkg::CMD_A: begin
						u.write = 1'b1;
						watch_setting = 1'b0;
					end
					default: ;
				endcase
			end
		end
		u.setting = watch_setting;
		u.field = watch_field;
		u.edit = watch_edit;
		u.rx_gap = p.rx_gap;
		return u;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	function automatic clock_time_t clock_at(int s, int mi, int h, int d, int mo, int y);
		clock_time_t t;
		t.sec = 6'(s);
		t.min = 6'(mi);
		t.hour = 5'(h);
		t.mday = 5'(d);
		t.month = 4'(mo);
		t.year = 8'(y);
		return t;
	endfunction

	// Any value the port widths allow, out-of-range ones included.
	function automatic clock_time_t any_clock();
		return clock_at($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
			$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 255));
	endfunction

	// A clock biased towards the values where the increments wrap: the last
	// seconds and minutes, late hours, month ends, February in leap and common
	// years (1900, 2000 and 2100 among them), and the out-of-range codes.
	function automatic clock_time_t boundary_clock();
		clock_time_t t;
		case ($urandom_range(0, 7))
			0: t.sec = 6'd0;
			1: t.sec = 6'd59;
			2: t.sec = 6'd58;
			3: t.sec = 6'($urandom_range(60, 63));
			default: t.sec = 6'($urandom_range(0, 59));
		endcase
		case ($urandom_range(0, 7))
			0: t.min = 6'd0;
			1: t.min = 6'd59;
			2: t.min = 6'd58;
			3: t.min = 6'($urandom_range(60, 63));
			default: t.min = 6'($urandom_range(0, 59));
		endcase
		case ($urandom_range(0, 7))
			0: t.hour = 5'd0;
			1: t.hour = 5'd23;
			2: t.hour = 5'd22;
			3: t.hour = 5'($urandom_range(24, 31));
			default: t.hour = 5'($urandom_range(0, 23));
		endcase
		case ($urandom_range(0, 9))
			0: t.mday = 5'd0;
			1: t.mday = 5'd1;
			2: t.mday = 5'd28;
			3: t.mday = 5'd29;
			4: t.mday = 5'd30;
			5: t.mday = 5'd31;
			default: t.mday = 5'($urandom_range(1, 31));
		endcase
		case ($urandom_range(0, 7))
			0, 1: t.month = 4'd1;
			2: t.month = 4'd11;
			3: t.month = 4'($urandom_range(12, 15));
			4: t.month = 4'd3;
			default: t.month = 4'($urandom_range(0, 11));
		endcase
		case ($urandom_range(0, 10))
			0: t.year = 8'd0;
			1: t.year = 8'd100;
			2: t.year = 8'd200;
			3: t.year = 8'd199;
			4: t.year = 8'd198;
			5: t.year = 8'd119;
			6: t.year = 8'($urandom_range(200, 255));
			7: t.year = 8'($urandom_range(0, 255));
			default: t.year = 8'($urandom_range(119, 199));
		endcase
		return t;
	endfunction

	// Queues one transaction. The idling pattern runs in phases of 150
	// transactions: both sides idle, neither idles, only the sender idles, and
	// only the receiver idles. The last phase keeps the sender busy while the
	// receiver is held off, so that the block fills and stalls its input.
	task automatic queue_press(wtsc_pkg::cmd_t c, bit act, clock_time_t s);
		button_press_t p;
		int phase;
		phase = (n_queued / 150) % 4;
		p.cmd = c;
		p.active = act;
		p.snap = s;
		p.tx_gap = (phase == 1 || phase == 3) ? 0 : $urandom_range(0, 16);
		p.rx_gap = (phase == 1 || phase == 2) ? 0 : $urandom_range(0, 16);
		// Now and then the sender waits until the block has nothing left to deliver.
		p.drain = (n_queued % 230 == 229);
		press_q.push_back(p);
		n_queued++;
		if (act) begin
			n_active++;
			if (c == wtsc_pkg::CMD_A)
				plan_setting = !plan_setting;
		end
	endtask

	// A press inside a session, sometimes preceded by an ignored transaction or an
	// active one without a button.
	task automatic press_with_noise(wtsc_pkg::cmd_t c);
		case ($urandom_range(0, 9))
			0: queue_press(wtsc_pkg::cmd_t'($urandom_range(0, 3)), 1'b0, any_clock());
			1: queue_press(wtsc_pkg::CMD_NONE, 1'b1, any_clock());
			default: ;
		endcase
		queue_press(c, 1'b1, any_clock());
	endtask

	// A well-formed setting session: enter with a boundary clock, pick fields with
	// C, step them with B, and usually leave again with A.
	task automatic setting_session();
		int rounds;
		int n_c;
		int n_b;
		if (plan_setting)
			queue_press(wtsc_pkg::CMD_A, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_A, 1'b1, boundary_clock());
		rounds = $urandom_range(1, 3);
		repeat (rounds) begin
			n_c = $urandom_range(0, 5);
			if ($urandom_range(0, 9) == 0)
				n_c += 6;
			repeat (n_c) press_with_noise(wtsc_pkg::CMD_C);
			// A rare long run of B presses carries a field all the way round.
			n_b = ($urandom_range(0, 29) == 0) ? $urandom_range(20, 70) :
				$urandom_range(0, 4);
			repeat (n_b) press_with_noise(wtsc_pkg::CMD_B);
		end
		if ($urandom_range(0, 9) != 0)
			queue_press(wtsc_pkg::CMD_A, 1'b1, any_clock());
	endtask

	// Directed opening: the reset state, an ignored transaction, B and C outside
	// setting, every field stepped from the largest codes the ports allow, C in
	// setting, write-back on exit, and a session entered from an all-zero clock
	// so that day zero is stepped in 1900.
	task automatic directed_presses();
		queue_press(wtsc_pkg::CMD_NONE, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_A, 1'b0, any_clock());
		queue_press(wtsc_pkg::CMD_C, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_B, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_A, 1'b1, clock_at(63, 63, 31, 31, 15, 255));
		// Seconds first, then hour, minute, year, month and day in selector order.
		repeat (6) begin
			queue_press(wtsc_pkg::CMD_B, 1'b1, any_clock());
			queue_press(wtsc_pkg::CMD_C, 1'b1, any_clock());
		end
		queue_press(wtsc_pkg::CMD_A, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_A, 1'b1, clock_at(0, 0, 0, 0, 0, 0));
		repeat (5) queue_press(wtsc_pkg::CMD_C, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_B, 1'b1, any_clock());
		queue_press(wtsc_pkg::CMD_A, 1'b1, any_clock());
	endtask

	// ------------------------------------------------------------------
	// Driver: offers one transaction at a time and feeds the model at acceptance
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bit go;
		go = 1'b0;
		if (in_valid && in_stall)
			n_in_stalls++;
		// A stalled transaction stays on the bus unchanged.
		if (arst_n && !(in_valid && in_stall)) begin
			if (in_valid) begin
				update_q.push_back(apply_press(cur_press));
				n_accepted++;
				have_press = 1'b0;
			end
			if (!have_press && press_q.size() > 0) begin
				cur_press = press_q.pop_front();
				have_press = 1'b1;
				tx_wait = cur_press.tx_gap;
			end
			if (have_press) begin
				if (tx_wait > 0)
					tx_wait--;
				else if (!cur_press.drain || update_q.size() == 0)
					go = 1'b1;
			end
			in_valid <= go;
			if (go) begin
				cmd <= cur_press.cmd;
				active <= cur_press.active;
				cur_sec <= cur_press.snap.sec;
				cur_min <= cur_press.snap.min;
				cur_hour <= cur_press.snap.hour;
				cur_mday <= cur_press.snap.mday;
				cur_month <= cur_press.snap.month;
				cur_year <= cur_press.snap.year;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: takes results and compares them with the oldest expectation
	// ------------------------------------------------------------------
	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_errors <= 40)
				$display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		watch_update_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (update_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 40)
						$display({"[%0t] result with no transaction outstanding: ",
							"expected none, actual setting_on %0d field_sel %0d"},
							$time, setting_on, field_sel);
				end else begin
					want = update_q.pop_front();
					check_field("setting_on", 8'(want.setting), 8'(setting_on));
					check_field("field_sel", 8'(want.field), 8'(field_sel));
					check_field("leave_mode", 8'(want.leave), 8'(leave_mode));
					check_field("write_clock", 8'(want.write), 8'(write_clock));
					check_field("out_sec", 8'(want.edit.sec), 8'(out_sec));
					check_field("out_min", 8'(want.edit.min), 8'(out_min));
					check_field("out_hour", 8'(want.edit.hour), 8'(out_hour));
					check_field("out_mday", 8'(want.edit.mday), 8'(out_mday));
					check_field("out_month", 8'(want.edit.month), 8'(out_month));
					check_field("out_year", want.edit.year, out_year);
					n_checked++;
					n_writes += int'(want.write);
					n_leaves += int'(want.leave);
					rx_wait = want.rx_gap;
				end
			end else if (out_valid && rx_wait > 0) begin
				// The stall is counted only while a result is actually held back.
				rx_wait--;
			end
			out_stall <= rx_block || (rx_wait > 0);
		end
	end

	// Long hold-off of the receiver during the phase in which the sender never
	// idles, so the result register fills and the block has to stall its input.
	initial begin
		while (n_accepted < 470)
			@(posedge clk);
		rx_block <= 1'b1;
		repeat (150) @(posedge clk);
		rx_block <= 1'b0;
	end

	// Safety net: far longer than the slowest correct run could take.
	initial begin
		#2_000_000;
		$display("** watch_time_setting_control: FAILED **");
		$finish;
	end

	// Main sequence: build the stimulus, release reset, wait for the driver to
	// run dry and for every result to arrive, then give the verdict.
	initial begin
		int n_noise;
		directed_presses();
		while (n_queued < 1650) begin
			if ($urandom_range(0, 3) != 0) begin
				setting_session();
			end else begin
				n_noise = $urandom_range(1, 4);
				repeat (n_noise)
					queue_press(wtsc_pkg::cmd_t'($urandom_range(0, 3)),
						$urandom_range(0, 3) != 0, any_clock());
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (have_press || press_q.size() > 0)
			@(posedge clk);
		while (update_q.size() > 0)
			@(posedge clk);
		// The extra edges below would show any stray result.
		repeat (10) @(posedge clk);
		$display("Run covered %0d button transactions (%0d active), %0d results checked,",
			n_accepted, n_active, n_checked);
		$display("%0d write-backs, %0d leave requests, %0d cycles with the input stalled.",
			n_writes, n_leaves, n_in_stalls);
		if (n_errors == 0) begin
			$display("** watch_time_setting_control: PASSED **");
		end else begin
			$display("** watch_time_setting_control: FAILED **");
		end
		$finish;
	end

endmodule
